// File: rtl/reactive_obstacle_speed_control_top_defines.svh
// Assertion macros for the reactive obstacle speed control block
`ifndef REACTIVE_OBSTACLE_SPEED_CONTROL_TOP_DEFINES_SVH
`define REACTIVE_OBSTACLE_SPEED_CONTROL_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define ROSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define ROSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rosc_pkg.sv
// Shared types, widths and constants of the obstacle speed controller
package rosc_pkg;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 13;
    localparam int SPEED_W  = 16;
    localparam int LIMIT_W  = 15;
    localparam int COUNT_W  = 16;

    // Configuration port
    localparam int NUM_REGS = 7;
    localparam int APB_DW   = 32;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);

    // Datapath widths
    localparam int DEN_W     = RANGE_W + 1;
    localparam int ERR_W     = ANGLE_W + 1;
    localparam int MUL_A_W   = 2 * RANGE_W + 2;
    localparam int MUL_B_W   = RANGE_W + 1;
    localparam int ACC_W     = MUL_A_W + MUL_B_W;
    localparam int QSHIFT    = 8;
    localparam int DIV_STEPS = SPEED_W;
    localparam int DIV_W     = RANGE_W + DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // pi/2 + 0.01 rad in mrad, and the round-toward-zero bias for a Q8.8 product
    localparam int HALF_PI_MRAD = 1581;
    localparam int TURN_BIAS    = (1 << QSHIFT) - 1;

    localparam logic signed [SPEED_W-1:0] SPEED_HI = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_LO = {1'b1, {(SPEED_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_FRAME = 2'd0,
        MODE_SIDE  = 2'd1,
        MODE_FRONT = 2'd2,
        MODE_CMD   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_SIDE_RANGE   = 3'd0,
        REG_FRONT_RANGE  = 3'd1,
        REG_DANGER_RANGE = 3'd2,
        REG_MIN_DISTANCE = 3'd3,
        REG_GAIN_TURN    = 3'd4,
        REG_GAIN_FORWARD = 3'd5,
        REG_OUTPUT_LIMIT = 3'd6
    } reg_idx_t;

    typedef enum logic {
        ALU_MUL,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [RANGE_W-1:0] side_range;
        logic [RANGE_W-1:0] frontal_range;
        logic [RANGE_W-1:0] frontal_danger_range;
        logic [RANGE_W-1:0] min_distance;
        logic [RANGE_W-1:0] gain_turn;
        logic [RANGE_W-1:0] gain_forward;
        logic [LIMIT_W-1:0] output_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        side_range:           16'd1000,
        frontal_range:        16'd2700,
        frontal_danger_range: 16'd2000,
        min_distance:         16'd300,
        gain_turn:            16'd512,
        gain_forward:         16'd256,
        output_limit:         15'd2000
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_at_min;
        logic                      left_lt_right;
        logic                      side_danger;
        logic [RANGE_W-1:0]        front_min;
        logic                      front_danger;
    } trk_t;

    typedef struct packed {
        alu_op_t                   op;
        logic signed [MUL_A_W-1:0] mul_a;
        logic signed [MUL_B_W-1:0] mul_b;
        logic [ACC_W-1:0]          sub_x;
        logic [ACC_W-1:0]          sub_y;
    } alu_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] res;
        logic             ge;
    } alu_rsp_t;

endpackage

// File: rtl/rosc_if.sv
// Handshake interfaces for input words and result words

interface rosc_item_if import rosc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [RANGE_W-1:0]        object_range;
    logic signed [ANGLE_W-1:0] object_angle;
    logic signed [SPEED_W-1:0] forward_command;
    logic signed [SPEED_W-1:0] turn_command;

    modport source (
        output valid, mode, object_range, object_angle, forward_command, turn_command,
        input  ready
    );
    modport sink (
        input  valid, mode, object_range, object_angle, forward_command, turn_command,
        output ready
    );
endinterface

interface rosc_result_if import rosc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] forward_speed;
    logic signed [SPEED_W-1:0] turn_rate;
    logic                      side_alarm;
    logic                      front_alarm;

    modport source (
        output valid, forward_speed, turn_rate, side_alarm, front_alarm,
        input  ready
    );
    modport sink (
        input  valid, forward_speed, turn_rate, side_alarm, front_alarm,
        output ready
    );
endinterface

// File: rtl/rosc_cfg.sv
// APB configuration register bank
module rosc_cfg import rosc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SIDE_RANGE:   cfg_reg.side_range           <= pwdata[RANGE_W-1:0];
                REG_FRONT_RANGE:  cfg_reg.frontal_range        <= pwdata[RANGE_W-1:0];
                REG_DANGER_RANGE: cfg_reg.frontal_danger_range <= pwdata[RANGE_W-1:0];
                REG_MIN_DISTANCE: cfg_reg.min_distance         <= pwdata[RANGE_W-1:0];
                REG_GAIN_TURN:    cfg_reg.gain_turn            <= pwdata[RANGE_W-1:0];
                REG_GAIN_FORWARD: cfg_reg.gain_forward         <= pwdata[RANGE_W-1:0];
                REG_OUTPUT_LIMIT: cfg_reg.output_limit         <= pwdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            REG_SIDE_RANGE:   prdata = APB_DW'(cfg_reg.side_range);
            REG_FRONT_RANGE:  prdata = APB_DW'(cfg_reg.frontal_range);
            REG_DANGER_RANGE: prdata = APB_DW'(cfg_reg.frontal_danger_range);
            REG_MIN_DISTANCE: prdata = APB_DW'(cfg_reg.min_distance);
            REG_GAIN_TURN:    prdata = APB_DW'(cfg_reg.gain_turn);
            REG_GAIN_FORWARD: prdata = APB_DW'(cfg_reg.gain_forward);
            REG_OUTPUT_LIMIT: prdata = APB_DW'(cfg_reg.output_limit);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/rosc_track.sv
// Per-frame obstacle tracking: running minima, counts and danger flags
module rosc_track import rosc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      upd,
    input  logic [MODE_W-1:0]         mode,
    input  logic [RANGE_W-1:0]        object_range,
    input  logic signed [ANGLE_W-1:0] object_angle,
    input  cfg_t                      cfg,
    output trk_t                      trk
);

    logic [RANGE_W-1:0]        side_min_reg;
    logic [RANGE_W-1:0]        front_min_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [COUNT_W-1:0]        right_cnt_reg;
    logic [COUNT_W-1:0]        left_cnt_reg;
    logic                      side_danger_reg;
    logic                      front_danger_reg;

    // Update the frame state on every accepted object or frame word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_min_reg     <= CFG_RESET.side_range;
            front_min_reg    <= CFG_RESET.frontal_range;
            angle_reg        <= '0;
            right_cnt_reg    <= '0;
            left_cnt_reg     <= '0;
            side_danger_reg  <= 1'b0;
            front_danger_reg <= 1'b0;
        end
        else if (upd)
        begin
            unique case (mode_t'(mode))
                MODE_FRAME:
                begin
                    side_min_reg     <= cfg.side_range;
                    front_min_reg    <= cfg.frontal_range;
                    angle_reg        <= '0;
                    right_cnt_reg    <= '0;
                    left_cnt_reg     <= '0;
                    side_danger_reg  <= 1'b0;
                    front_danger_reg <= 1'b0;
                end
                MODE_SIDE:
                begin
                    if (object_range < cfg.side_range)
                    begin
                        side_danger_reg <= 1'b1;
                    end
                    // Take a new minimum and count its side, saturating
                    if (object_range < side_min_reg)
                    begin
                        side_min_reg <= object_range;
                        angle_reg    <= object_angle;
                        if (object_angle <= $signed(ANGLE_W'(0)))
                        begin
                            if (right_cnt_reg != '1)
                            begin
                                right_cnt_reg <= right_cnt_reg + COUNT_W'(1);
                            end
                        end
                        else if (left_cnt_reg != '1)
                        begin
                            left_cnt_reg <= left_cnt_reg + COUNT_W'(1);
                        end
                    end
                end
                MODE_FRONT:
                begin
                    if (object_range < cfg.frontal_danger_range)
                    begin
                        front_danger_reg <= 1'b1;
                    end
                    if (object_range < front_min_reg)
                    begin
                        front_min_reg <= object_range;
                    end
                end
                MODE_CMD: ;
            endcase
        end
    end

    assign trk.angle_at_min  = angle_reg;
    assign trk.left_lt_right = left_cnt_reg < right_cnt_reg;
    assign trk.side_danger   = side_danger_reg;
    assign trk.front_min     = front_min_reg;
    assign trk.front_danger  = front_danger_reg;

endmodule

// File: rtl/rosc_alu.sv
// Shared arithmetic unit: one signed multiplier and one wide compare-subtract
module rosc_alu import rosc_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic signed [ACC_W-1:0] prod;
    logic [ACC_W-1:0]        diff;
    logic                    borrow;

    assign prod             = req.mul_a * req.mul_b;
    assign {borrow, diff}   = {1'b0, req.sub_x} - {1'b0, req.sub_y};

    // Select the unit result for the current step
    always_comb
    begin
        case (req.op)
            ALU_MUL: rsp.res = prod;
            default: rsp.res = diff;
        endcase
        rsp.ge = ~borrow;
    end

endmodule

// File: rtl/reactive_obstacle_speed_control_top.sv
// Object and frame words leave the sequencer idle, so the block stays ready for the next word.
// A command word with no danger goes straight to the final step, which registers its result word
// once the result register is free; side danger adds the turn multiply and rounding, and frontal
// danger adds the forward multiplies, the sign fold, a range check and the 16-step restoring divide.
// Reset is asynchronous, active low: registers take their defaults, the minima
// start at the default ranges, and the held speeds start at zero.
`include "reactive_obstacle_speed_control_top_defines.svh"

module reactive_obstacle_speed_control_top import rosc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    rosc_item_if.sink         item,
    rosc_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TMUL,
        S_TFIN,
        S_FMUL1,
        S_FMUL2,
        S_FABS,
        S_FCHK,
        S_FDIV,
        S_FSAT,
        S_DONE
    } state_t;

    localparam logic [DIV_STEPS-1:0] QPOS_MAX = DIV_STEPS'(2 ** (SPEED_W - 1) - 1);
    localparam logic [DIV_STEPS-1:0] QNEG_MAX = DIV_STEPS'(2 ** (SPEED_W - 1));

    cfg_t     cfg;
    trk_t     trk;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    state_t                    state_reg;
    logic signed [SPEED_W-1:0] fcmd_reg;
    logic signed [SPEED_W-1:0] fwd_reg;
    logic signed [SPEED_W-1:0] turn_reg;
    logic signed [SPEED_W-1:0] last_fwd_reg;
    logic signed [SPEED_W-1:0] last_turn_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic                      neg_reg;
    logic [DIV_W-1:0]          rem_reg;
    logic [DIV_W-1:0]          dsh_reg;
    logic [DIV_STEPS-1:0]      quo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      res_valid_reg;
    logic signed [SPEED_W-1:0] res_fwd_reg;
    logic signed [SPEED_W-1:0] res_turn_reg;
    logic                      res_side_reg;
    logic                      res_front_reg;

    logic                      item_acc;
    logic                      res_load;
    logic                      obj_acc;
    logic                      out_in_limit;
    logic [ANGLE_W-1:0]        ang_abs;
    logic signed [ERR_W-1:0]   turn_err;
    logic signed [MUL_B_W-1:0] turn_b;
    logic signed [DEN_W-1:0]   den;
    logic signed [DEN_W-1:0]   num;
    logic [RANGE_W-1:0]        den_abs;
    logic signed [SPEED_W-1:0] limit_top;
    logic [DIV_W:0]            dsh_x2;
    logic signed [SPEED_W-1:0] fwd_clamped;
    logic signed [SPEED_W-1:0] turn_clamped;

    // Clamp at the upper output limit
    function automatic logic signed [SPEED_W-1:0] clamp_top(
        input logic signed [SPEED_W-1:0] v,
        input logic signed [SPEED_W-1:0] lim
    );
        return (v > lim) ? lim : v;
    endfunction

    // Saturate a wide signed value into the speed field
    function automatic logic signed [SPEED_W-1:0] sat_speed(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > ACC_W'(SPEED_HI))
            r = SPEED_HI;
        else if (v < ACC_W'(SPEED_LO))
            r = SPEED_LO;
        else
            r = v[SPEED_W-1:0];
        return r;
    endfunction

    // Apply the sign to a quotient magnitude and saturate
    function automatic logic signed [SPEED_W-1:0] div_sat(
        input logic [DIV_STEPS-1:0] q,
        input logic                 neg
    );
        logic signed [DIV_STEPS:0] qn;
        logic signed [SPEED_W-1:0] r;
        qn = -$signed({1'b0, q});
        if (neg)
            r = (q > QNEG_MAX) ? SPEED_LO : qn[SPEED_W-1:0];
        else
            r = (q > QPOS_MAX) ? SPEED_HI : q[SPEED_W-1:0];
        return r;
    endfunction

    rosc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rosc_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (item_acc),
        .mode         (item.mode),
        .object_range (item.object_range),
        .object_angle (item.object_angle),
        .cfg          (cfg),
        .trk          (trk)
    );

    rosc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid & item.ready;
    assign res_load   = (state_reg == S_DONE) && (!res_valid_reg || result.ready);

    // Steering error from the angle of the nearest side object
    assign ang_abs  = trk.angle_at_min[ANGLE_W-1] ? $unsigned(-trk.angle_at_min)
                                                  : $unsigned(trk.angle_at_min);
    assign turn_err = $signed(ERR_W'(HALF_PI_MRAD)) - $signed({1'b0, ang_abs});
    assign turn_b   = trk.left_lt_right ? MUL_B_W'(turn_err) : MUL_B_W'(-turn_err);

    // Frontal scaling terms
    assign den     = $signed({1'b0, cfg.frontal_range}) - $signed({1'b0, cfg.min_distance});
    assign num     = $signed({1'b0, trk.front_min}) - $signed({1'b0, cfg.min_distance});
    assign den_abs = den[DEN_W-1] ? RANGE_W'(-den) : den[RANGE_W-1:0];

    assign limit_top    = $signed(SPEED_W'(cfg.output_limit));
    assign dsh_x2       = {dsh_reg, 1'b0};
    assign fwd_clamped  = clamp_top(fwd_reg, limit_top);
    assign turn_clamped = clamp_top(turn_reg, limit_top);

    // Drive the shared unit for the current step
    always_comb
    begin
        alu_req    = '0;
        alu_req.op = ALU_SUB;
        unique case (state_reg)
            S_TMUL:
            begin
                alu_req.op    = ALU_MUL;
                alu_req.mul_a = $signed(MUL_A_W'(cfg.gain_turn));
                alu_req.mul_b = turn_b;
            end
            S_TFIN:
            begin
                alu_req.sub_x = acc_reg;
                alu_req.sub_y = acc_reg[ACC_W-1] ? ACC_W'(-TURN_BIAS) : '0;
            end
            S_FMUL1:
            begin
                alu_req.op    = ALU_MUL;
                alu_req.mul_a = MUL_A_W'(num);
                alu_req.mul_b = $signed(MUL_B_W'(cfg.gain_forward));
            end
            S_FMUL2:
            begin
                alu_req.op    = ALU_MUL;
                alu_req.mul_a = $signed(acc_reg[MUL_A_W-1:0]);
                alu_req.mul_b = MUL_B_W'(fcmd_reg);
            end
            S_FABS:
            begin
                alu_req.sub_x = '0;
                alu_req.sub_y = acc_reg;
            end
            S_FCHK:
            begin
                alu_req.sub_x = ACC_W'(acc_reg[ACC_W-1:QSHIFT]);
                alu_req.sub_y = ACC_W'(dsh_x2);
            end
            S_FDIV:
            begin
                alu_req.sub_x = ACC_W'(rem_reg);
                alu_req.sub_y = ACC_W'(dsh_reg);
            end
            default: ;
        endcase
    end

    // Sequence the command word and hold the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fcmd_reg      <= '0;
            fwd_reg       <= '0;
            turn_reg      <= '0;
            last_fwd_reg  <= '0;
            last_turn_reg <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            rem_reg       <= '0;
            dsh_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_fwd_reg   <= '0;
            res_turn_reg  <= '0;
            res_side_reg  <= 1'b0;
            res_front_reg <= 1'b0;
        end
        else
        begin
            // Load a new result word from the final step, else drop it once taken
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_acc && (item.mode == MODE_CMD))
                    begin
                        fcmd_reg <= item.forward_command;
                        if (!trk.side_danger && !trk.front_danger)
                        begin
                            fwd_reg   <= item.forward_command;
                            turn_reg  <= item.turn_command;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            fwd_reg   <= last_fwd_reg;
                            turn_reg  <= last_turn_reg;
                            state_reg <= trk.side_danger ? S_TMUL : S_FMUL1;
                        end
                    end
                end
                S_TMUL:
                begin
                    acc_reg   <= alu_rsp.res;
                    state_reg <= S_TFIN;
                end
                S_TFIN:
                begin
                    turn_reg  <= sat_speed($signed(alu_rsp.res) >>> QSHIFT);
                    state_reg <= trk.front_danger ? S_FMUL1 : S_DONE;
                end
                S_FMUL1:
                begin
                    if (den == '0)
                    begin
                        fwd_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        acc_reg   <= alu_rsp.res;
                        neg_reg   <= den[DEN_W-1];
                        dsh_reg   <= DIV_W'(den_abs) << (DIV_STEPS - 1);
                        state_reg <= S_FMUL2;
                    end
                end
                S_FMUL2:
                begin
                    acc_reg   <= alu_rsp.res;
                    state_reg <= S_FABS;
                end
                S_FABS:
                begin
                    // Fold the product sign into the quotient sign, keep the magnitude
                    neg_reg <= neg_reg ^ acc_reg[ACC_W-1];
                    if (acc_reg[ACC_W-1])
                    begin
                        acc_reg <= alu_rsp.res;
                    end
                    state_reg <= S_FCHK;
                end
                S_FCHK:
                begin
                    // Quotient of 2^16 or more saturates without dividing
                    if (alu_rsp.ge)
                    begin
                        quo_reg   <= '1;
                        state_reg <= S_FSAT;
                    end
                    else
                    begin
                        rem_reg   <= acc_reg[QSHIFT +: DIV_W];
                        cnt_reg   <= '0;
                        state_reg <= S_FDIV;
                    end
                end
                S_FDIV:
                begin
                    if (alu_rsp.ge)
                    begin
                        rem_reg <= alu_rsp.res[DIV_W-1:0];
                    end
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], alu_rsp.ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_FSAT;
                    end
                end
                S_FSAT:
                begin
                    fwd_reg   <= div_sat(quo_reg, neg_reg);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Load the result word once the register is free
                    if (res_load)
                    begin
                        res_fwd_reg   <= fwd_clamped;
                        res_turn_reg  <= turn_clamped;
                        res_side_reg  <= trk.side_danger;
                        res_front_reg <= trk.front_danger;
                        last_fwd_reg  <= fwd_clamped;
                        last_turn_reg <= turn_clamped;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.forward_speed = res_fwd_reg;
    assign result.turn_rate     = res_turn_reg;
    assign result.side_alarm    = res_side_reg;
    assign result.front_alarm   = res_front_reg;

    assign obj_acc      = item_acc && (item.mode != MODE_CMD);
    assign out_in_limit = (result.forward_speed <= limit_top) && (result.turn_rate <= limit_top);

    // Object and frame words never start the sequencer
    `ROSC_ASSERT_NEXT(a_obj_idle, obj_acc, state_reg == S_IDLE, "object word left idle")
    // Both outputs respect the upper limit
    `ROSC_ASSERT_IMPL(a_output_limit, result.valid, out_in_limit, "result word above output limit")
    // A new result word comes only out of the final step
    `ROSC_ASSERT_NEXT(a_load_done, !result.valid && !res_load, !result.valid, "stray result word")
    // The partial remainder stays below twice the shifted divisor
    `ROSC_ASSERT_IMPL(a_div_rem, state_reg == S_FDIV, rem_reg < dsh_x2, "remainder out of range")

endmodule
